/* design/assert_macros.svh */
// Assertion macros shared by the complex EMA design files.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define CEMA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define CEMA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

/* design/cema_pkg.sv */
// Shared constants, register indexes and types of the complex EMA block.
// No dependencies; imported by every module of the block.
package cema_pkg;

    localparam int ACC_BITS_DEF = 32;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int STATE_W      = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 64;

    localparam int FRAC_SHIFT   = 15;
    localparam int GAIN_ALIGN   = 9;
    localparam int ROUND_HALF   = 16384;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_IM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 2'd2;

    localparam logic signed [COEF_W-1:0] DECAY_RE_RST   = 16'sd29491;
    localparam logic signed [COEF_W-1:0] DECAY_IM_RST   = 16'sd0;
    localparam logic signed [COEF_W-1:0] INPUT_GAIN_RST = 16'sd16384;

    typedef struct packed {
        logic fire;
        logic first;
        logic last;
    } cema_ctrl_t;

endpackage

/* design/complex_ema_hidden_forward.sv */
// Top level of the complex one-pole EMA: configuration registers, input stage, datapath.
// Depends on cema_pkg, cema_state, cema_out and assert_macros.svh.
//
//  Channel  Direction  Handshake            Word contents (lowest bit first)
//  cfg      in         cfg_we               cfg_index selects register, cfg_wdata
//  s_       in         s_tvalid / s_tready  tdata: sample, init_re, init_im; tuser: first;
//                                           tlast: last
//  m_       out        m_tvalid / m_tready  tdata: hidden_re, hidden_im; tuser: saturated
//
// One word is taken per cycle while the input stage is not stalled; each word is held in
// the input register, and a last word writes the result register when it moves on.
// The step is combinational: four 16 x ACC_BITS products, one sum per lane and saturation.
// Reset clears the accumulator, the clip flag and both valid flags, and loads the
// register defaults. A held result stalls the input stage only when the word waiting in
// the input stage carries last.
`include "assert_macros.svh"

module complex_ema_hidden_forward import cema_pkg::*; #(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample[15:0], init_re[47:16], init_im[79:48]
    input  logic [0:0]            s_tuser,   // first[0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // hidden_re[31:0], hidden_im[63:32]
    output logic [0:0]            m_tuser    // saturated[0]
);

    logic signed [COEF_W-1:0]   decay_re_reg;
    logic signed [COEF_W-1:0]   decay_im_reg;
    logic signed [COEF_W-1:0]   input_gain_reg;

    logic                       stage_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [STATE_W-1:0]  init_re_reg;
    logic signed [STATE_W-1:0]  init_im_reg;
    logic                       first_reg;
    logic                       last_reg;

    logic                       fire;
    cema_ctrl_t                 ctrl;
    logic signed [ACC_BITS-1:0] acc_re_next;
    logic signed [ACC_BITS-1:0] acc_im_next;
    logic                       seq_clip;
    logic                       out_clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_re_reg   <= DECAY_RE_RST;
            decay_im_reg   <= DECAY_IM_RST;
            input_gain_reg <= INPUT_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DECAY_RE:   decay_re_reg   <= cfg_wdata;
                CFG_DECAY_IM:   decay_im_reg   <= cfg_wdata;
                CFG_INPUT_GAIN: input_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The word in the input stage moves on unless it needs the result register
    // and that register still holds an untaken result.
    assign fire     = stage_valid_reg && (!last_reg || !m_tvalid || m_tready);
    assign s_tready = !stage_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_tready) begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg  <= s_tdata[15:0];
            init_re_reg <= s_tdata[47:16];
            init_im_reg <= s_tdata[79:48];
            first_reg   <= s_tuser[0];
            last_reg    <= s_tlast;
        end
    end

    assign ctrl.fire  = fire;
    assign ctrl.first = first_reg;
    assign ctrl.last  = last_reg;

    cema_state #(.ACC_W(ACC_BITS)) u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .sample      (sample_reg),
        .init_re     (init_re_reg),
        .init_im     (init_im_reg),
        .decay_re    (decay_re_reg),
        .decay_im    (decay_im_reg),
        .input_gain  (input_gain_reg),
        .out_clip    (out_clip),
        .acc_re_next (acc_re_next),
        .acc_im_next (acc_im_next),
        .seq_clip    (seq_clip)
    );

    cema_out #(.ACC_W(ACC_BITS)) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .acc_re_next (acc_re_next),
        .acc_im_next (acc_im_next),
        .seq_clip    (seq_clip),
        .out_clip    (out_clip),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    `CEMA_ASSERT(a_stage_holds, aclk, aresetn,
        stage_valid_reg && !fire |=> stage_valid_reg && $stable(sample_reg),
        "stalled input stage lost its word")
    `CEMA_ASSERT(a_last_gives_result, aclk, aresetn,
        fire && last_reg |=> m_tvalid,
        "last word did not load the result register")
    `CEMA_ASSERT_NEVER(a_no_overwrite, aclk, aresetn,
        fire && last_reg && m_tvalid && !m_tready,
        "result register overwritten before it was taken")

endmodule

/* design/cema_mac.sv */
// One lane of the complex multiply-add: a*c -/+ b*d + gain term, rounded and saturated.
// Depends on cema_pkg.
module cema_mac import cema_pkg::*; #(
    parameter int ACC_W = ACC_BITS_DEF
) (
    input  logic signed [COEF_W-1:0]  coef_a,
    input  logic signed [ACC_W-1:0]   val_a,
    input  logic signed [COEF_W-1:0]  coef_b,
    input  logic signed [ACC_W-1:0]   val_b,
    input  logic                      sub_b,
    input  logic signed [STATE_W-1:0] gain_x,
    output logic signed [ACC_W-1:0]   result,
    output logic                      clip
);

    localparam int PROD_W = ACC_W + COEF_W;
    localparam int SUM_W  = ACC_W + 18;
    localparam int RES_W  = SUM_W - FRAC_SHIFT;

    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
    logic signed [SUM_W-1:0]  term_b;
    logic signed [SUM_W-1:0]  sum;
    logic signed [RES_W-1:0]  rounded;
    logic                     in_range;

    assign prod_a = PROD_W'(coef_a) * PROD_W'(val_a);
    assign prod_b = PROD_W'(coef_b) * PROD_W'(val_b);
    assign term_b = sub_b ? -SUM_W'(prod_b) : SUM_W'(prod_b);

    assign sum = SUM_W'(prod_a) + term_b + (SUM_W'(gain_x) <<< GAIN_ALIGN)
               + SUM_W'(ROUND_HALF);

    assign rounded  = sum[SUM_W-1:FRAC_SHIFT];
    assign in_range = (rounded[RES_W-1:ACC_W-1] == '0) || (rounded[RES_W-1:ACC_W-1] == '1);

    always_comb begin
        if (in_range) begin
            result = rounded[ACC_W-1:0];
        end else if (rounded[RES_W-1]) begin
            result = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    assign clip = !in_range;

endmodule

/* design/cema_state.sv */
// Accumulator state and recurrence step acc = q*acc + p*x, with the sticky clip flag.
// Depends on cema_pkg and cema_mac.
module cema_state import cema_pkg::*; #(
    parameter int ACC_W = ACC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cema_ctrl_t                ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [STATE_W-1:0] init_re,
    input  logic signed [STATE_W-1:0] init_im,
    input  logic signed [COEF_W-1:0]  decay_re,
    input  logic signed [COEF_W-1:0]  decay_im,
    input  logic signed [COEF_W-1:0]  input_gain,
    input  logic                      out_clip,
    output logic signed [ACC_W-1:0]   acc_re_next,
    output logic signed [ACC_W-1:0]   acc_im_next,
    output logic                      seq_clip
);

    logic signed [ACC_W-1:0]   acc_re_reg;
    logic signed [ACC_W-1:0]   acc_im_reg;
    logic                      clip_reg;
    logic                      clip_next;
    logic signed [ACC_W-1:0]   init_re_sat;
    logic signed [ACC_W-1:0]   init_im_sat;
    logic                      init_clip;
    logic signed [ACC_W-1:0]   base_re;
    logic signed [ACC_W-1:0]   base_im;
    logic signed [STATE_W-1:0] gain_x;
    logic                      clip_re;
    logic                      clip_im;

    if (ACC_W >= STATE_W) begin : g_init_wide
        assign init_re_sat = ACC_W'(init_re);
        assign init_im_sat = ACC_W'(init_im);
        assign init_clip   = 1'b0;
    end else begin : g_init_narrow
        logic re_ok;
        logic im_ok;

        assign re_ok = (init_re[STATE_W-1:ACC_W-1] == '0) || (init_re[STATE_W-1:ACC_W-1] == '1);
        assign im_ok = (init_im[STATE_W-1:ACC_W-1] == '0) || (init_im[STATE_W-1:ACC_W-1] == '1);
        assign init_re_sat = re_ok ? init_re[ACC_W-1:0]
                           : {init_re[STATE_W-1], {(ACC_W-1){!init_re[STATE_W-1]}}};
        assign init_im_sat = im_ok ? init_im[ACC_W-1:0]
                           : {init_im[STATE_W-1], {(ACC_W-1){!init_im[STATE_W-1]}}};
        assign init_clip   = !(re_ok && im_ok);
    end

    assign base_re = ctrl.first ? init_re_sat : acc_re_reg;
    assign base_im = ctrl.first ? init_im_sat : acc_im_reg;
    assign gain_x  = STATE_W'(input_gain) * STATE_W'(sample);

    cema_mac #(.ACC_W(ACC_W)) u_mac_re (
        .coef_a (decay_re),
        .val_a  (base_re),
        .coef_b (decay_im),
        .val_b  (base_im),
        .sub_b  (1'b1),
        .gain_x (gain_x),
        .result (acc_re_next),
        .clip   (clip_re)
    );

    cema_mac #(.ACC_W(ACC_W)) u_mac_im (
        .coef_a (decay_re),
        .val_a  (base_im),
        .coef_b (decay_im),
        .val_b  (base_re),
        .sub_b  (1'b0),
        .gain_x ('0),
        .result (acc_im_next),
        .clip   (clip_im)
    );

    assign seq_clip  = (ctrl.first ? 1'b0 : clip_reg) | (ctrl.first & init_clip)
                     | clip_re | clip_im;
    assign clip_next = seq_clip | out_clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
            clip_reg   <= 1'b0;
        end else if (ctrl.fire) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
            clip_reg   <= clip_next;
        end
    end

endmodule

/* design/cema_out.sv */
// Result register: narrows the accumulator to 32 bits and holds the result word.
// Depends on cema_pkg.
module cema_out import cema_pkg::*; #(
    parameter int ACC_W = ACC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cema_ctrl_t               ctrl,
    input  logic signed [ACC_W-1:0]  acc_re_next,
    input  logic signed [ACC_W-1:0]  acc_im_next,
    input  logic                     seq_clip,
    output logic                     out_clip,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]               m_tuser
);

    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_sat_reg;
    logic signed [STATE_W-1:0] hidden_re;
    logic signed [STATE_W-1:0] hidden_im;
    logic                      narrow_clip;

    if (ACC_W > STATE_W) begin : g_out_wide
        logic re_ok;
        logic im_ok;

        assign re_ok = (acc_re_next[ACC_W-1:STATE_W-1] == '0)
                    || (acc_re_next[ACC_W-1:STATE_W-1] == '1);
        assign im_ok = (acc_im_next[ACC_W-1:STATE_W-1] == '0)
                    || (acc_im_next[ACC_W-1:STATE_W-1] == '1);
        assign hidden_re = re_ok ? acc_re_next[STATE_W-1:0]
                         : {acc_re_next[ACC_W-1], {(STATE_W-1){!acc_re_next[ACC_W-1]}}};
        assign hidden_im = im_ok ? acc_im_next[STATE_W-1:0]
                         : {acc_im_next[ACC_W-1], {(STATE_W-1){!acc_im_next[ACC_W-1]}}};
        assign narrow_clip = !(re_ok && im_ok);
    end else begin : g_out_narrow
        assign hidden_re   = STATE_W'(acc_re_next);
        assign hidden_im   = STATE_W'(acc_im_next);
        assign narrow_clip = 1'b0;
    end

    assign out_clip = ctrl.last & narrow_clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.fire && ctrl.last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fire && ctrl.last) begin
            m_tdata_reg <= {hidden_im, hidden_re};
            m_sat_reg   <= seq_clip | narrow_clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_sat_reg;

endmodule

/* tb/tb_complex_ema_hidden_forward.sv */
// Self-checking testbench for the complex one-pole EMA block, driven over its stream ports.
// Depends on cema_pkg and complex_ema_hidden_forward; a built-in predictor gives the
// expected hidden state of every sequence and a scoreboard compares each result word.
module tb_complex_ema_hidden_forward;
    import cema_pkg::*;

    localparam int ACC_W      = ACC_BITS_DEF;
    localparam int SETTLE     = 4;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 200;

    typedef struct packed {
        logic [STATE_W-1:0] hidden_re;
        logic [STATE_W-1:0] hidden_im;
        logic               saturated;
    } hidden_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DECAY_RE;
    logic [COEF_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // sample[15:0], init_re[47:16], init_im[79:48]
    logic [0:0]           s_tuser   = '0;   // first[0]
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // hidden_re[31:0], hidden_im[63:32]
    logic [0:0]           m_tuser;          // saturated[0]

    logic signed [COEF_W-1:0] decay_re_m = DECAY_RE_RST;
    logic signed [COEF_W-1:0] decay_im_m = DECAY_IM_RST;
    logic signed [COEF_W-1:0] gain_m     = INPUT_GAIN_RST;
    longint  acc_re_m  = 0;
    longint  acc_im_m  = 0;
    bit      clip_m    = 1'b0;
    bit      step_clip = 1'b0;
    hidden_t pending_hidden[$];
    hidden_t want_hidden;

    int errors      = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_max     = 4;
    int hold_req    = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    complex_ema_hidden_forward dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_acc(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            step_clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            step_clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // a*c - b*d + gx aligned to 31 fraction bits, rounded half up to 16 fraction bits.
    function automatic longint rotate_mac(longint a, longint c, longint b, longint d,
                                          longint gx);
        return clamp_acc((a * c - b * d + (gx <<< GAIN_ALIGN) + ROUND_HALF) >>> FRAC_SHIFT,
                         ACC_W);
    endfunction

    task automatic advance_ema(logic [SAMPLE_W-1:0] sample, logic first, logic last,
                               logic [STATE_W-1:0] init_re, logic [STATE_W-1:0] init_im);
        longint  x;
        longint  qr;
        longint  qi;
        longint  g;
        longint  base_re;
        longint  base_im;
        longint  nre;
        longint  nim;
        longint  ore;
        longint  oim;
        hidden_t res;
        x         = $signed(sample);
        qr        = decay_re_m;
        qi        = decay_im_m;
        g         = gain_m;
        base_re   = acc_re_m;
        base_im   = acc_im_m;
        step_clip = 1'b0;
        if (first) begin
            clip_m  = 1'b0;
            base_re = clamp_acc($signed(init_re), ACC_W);
            base_im = clamp_acc($signed(init_im), ACC_W);
        end
        nre      = rotate_mac(qr, base_re, qi, base_im, g * x);
        nim      = rotate_mac(qr, base_im, -qi, base_re, 0);
        acc_re_m = nre;
        acc_im_m = nim;
        if (step_clip)
            clip_m = 1'b1;
        if (last) begin
            step_clip = 1'b0;
            ore = clamp_acc(acc_re_m, STATE_W);
            oim = clamp_acc(acc_im_m, STATE_W);
            if (step_clip)
                clip_m = 1'b1;
            res.hidden_re = ore[STATE_W-1:0];
            res.hidden_im = oim[STATE_W-1:0];
            res.saturated = clip_m;
            pending_hidden.push_back(res);
        end
    endtask

    task automatic send_word(logic [SAMPLE_W-1:0] sample, logic first, logic last,
                             logic [STATE_W-1:0] init_re, logic [STATE_W-1:0] init_im);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {init_im, init_re, sample};
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        advance_ema(sample, first, last, init_re, init_im);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_hidden.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_config(logic [COEF_W-1:0] re, logic [COEF_W-1:0] im,
                              logic [COEF_W-1:0] gain);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DECAY_RE;
        cfg_wdata <= re;
        @(negedge aclk);
        cfg_index <= CFG_DECAY_IM;
        cfg_wdata <= im;
        @(negedge aclk);
        cfg_index <= CFG_INPUT_GAIN;
        cfg_wdata <= gain;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        decay_re_m = re;
        decay_im_m = im;
        gain_m     = gain;
    endtask

    task automatic send_sequence(int len);
        logic [STATE_W-1:0] ire;
        logic [STATE_W-1:0] iim;
        logic [STATE_W-1:0] r1;
        logic [STATE_W-1:0] r2;
        r1 = $urandom;
        r2 = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                ire = '0;
                iim = '0;
            end
            1: begin
                ire = r1;
                iim = r2;
            end
            2: begin
                ire = {{12{r1[19]}}, r1[19:0]};
                iim = {{12{r2[19]}}, r2[19:0]};
            end
            default: begin
                ire = r1[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
                iim = r2[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
        endcase
        for (int k = 0; k < len; k++)
            send_word(SAMPLE_W'($urandom_range(0, 65535)), k == 0, k == len - 1,
                      (k == 0) ? ire : $urandom, (k == 0) ? iim : $urandom);
    endtask

    task automatic test_default_settings();
        send_word(16'h7FFF, 1'b0, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0);
        send_word(16'h8000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(16'h7FFF, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_word(16'h0100, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(16'hFF00, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_word(16'h0001, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_word(16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_extreme_settings();
        set_config(16'h8000, 16'h7FFF, 16'h8000);
        send_word(16'h8000, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_word(16'h7FFF, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
        set_config(16'h7FFF, 16'h8000, 16'h7FFF);
        send_word(16'h7FFF, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(16'h7FFF, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
        set_config(16'h0000, 16'h0000, 16'h0000);
        send_word(16'h5A5A, 1'b1, 1'b1, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        set_config(16'hFFFF, 16'h0001, 16'h0001);
        send_word(16'hFFFF, 1'b1, 1'b0, 32'h0001_0000, 32'hFFFF_0000);
        send_word(16'h0001, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_backpressure();
        set_config(DECAY_RE_RST, 16'h0800, INPUT_GAIN_RST);
        gap_max  = 0;
        hold_req = LONG_HOLD;
        repeat (24)
            send_word(SAMPLE_W'($urandom_range(0, 65535)), 1'b1, 1'b1, $urandom, $urandom);
        gap_max = 4;
        wait_idle();
    endtask

    task automatic test_random_sequences();
        int sent;
        int len;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase % 2 == 1)
                set_config(COEF_W'($urandom_range(0, 65535)), COEF_W'($urandom_range(0, 65535)),
                           COEF_W'($urandom_range(0, 65535)));
            else
                set_config(COEF_W'($urandom_range(16384, 32000)),
                           COEF_W'($urandom_range(0, 8000) - 4000),
                           COEF_W'($urandom_range(0, 65535)));
            gap_max = (phase % 3 == 0) ? 0 : 6;
            sent = 0;
            while (sent < 80) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 8);
                    send_sequence(len);
                    sent += len;
                end else begin
                    send_word(SAMPLE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom, $urandom);
                    sent++;
                end
            end
        end
        gap_max = 4;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_default_settings();
        test_extreme_settings();
        test_backpressure();
        test_random_sequences();
        wait_idle();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver follows its own pattern of ready and stalled stretches, with an
    // occasional long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_field(string name, logic [STATE_W-1:0] want, logic [STATE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hidden.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want_hidden = pending_hidden.pop_front();
                check_field("hidden_re", want_hidden.hidden_re, m_tdata[31:0]);
                check_field("hidden_im", want_hidden.hidden_im, m_tdata[63:32]);
                check_field("saturated", STATE_W'(want_hidden.saturated),
                            STATE_W'(m_tuser[0]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
